// ----- rtl/utf8d_pkg.sv -----
// Shared types and constants of the UTF-8 code point decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int CP_WIDTH   = 21;
   localparam int BYTE_WIDTH = 8;

   // Smallest value that each form may legally carry.
   localparam logic [CP_WIDTH-1:0] MIN_TWO_BYTE   = 21'h00080;
   localparam logic [CP_WIDTH-1:0] MIN_THREE_BYTE = 21'h00800;
   localparam logic [CP_WIDTH-1:0] MIN_FOUR_BYTE  = 21'h10000;

   // Continuation bytes of the current form.
   localparam logic [1:0] LEN_TWO_BYTE   = 2'd1;
   localparam logic [1:0] LEN_THREE_BYTE = 2'd2;
   localparam logic [1:0] LEN_FOUR_BYTE  = 2'd3;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                malformed;
      logic                last_of_run;
   } result_type;

   // Up to two results written into the queue in one cycle.
   typedef struct packed {
      logic       wr0;
      logic       wr1;
      result_type entry0;
      result_type entry1;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } queue_status_type;

endpackage

// ----- rtl/utf8d_front.sv -----
// Front part: takes text bytes, tracks the open sequence and classifies each byte.
`timescale 1ns / 1ps

module utf8d_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [utf8d_pkg::BYTE_WIDTH-1:0]     text_byte,
   output utf8d_pkg::push_type                  push
);

   logic [utf8d_pkg::CP_WIDTH-1:0] pv_ff, pv_in;
   logic [1:0]                     rem_ff, rem_in;
   logic [1:0]                     len_ff, len_in;

   logic                           cont;
   logic                           lead_emit, lead_bad, lead_start;
   logic [utf8d_pkg::CP_WIDTH-1:0] lead_cp, lead_pv;
   logic [1:0]                     lead_rem;
   logic [1:0]                     rem_dec;
   logic [utf8d_pkg::CP_WIDTH-1:0] shifted, value;
   logic                           overlong;
   utf8d_pkg::push_type            push_c;

   always_comb begin
      cont = (text_byte[7:6] == 2'b10);

      // Decode of the byte as the start of a new form.
      lead_emit  = 1'b0;
      lead_bad   = 1'b0;
      lead_cp    = '0;
      lead_start = 1'b0;
      lead_pv    = '0;
      lead_rem   = 2'd0;
      if (text_byte == 8'h00 || cont) begin
         lead_emit = 1'b0;
      end else if (!text_byte[7]) begin
         lead_emit = 1'b1;
         lead_cp   = {13'd0, text_byte};
      end else if (text_byte[7:5] == 3'b110) begin
         lead_start = 1'b1;
         lead_pv    = {10'd0, text_byte[4:0], 6'd0};
         lead_rem   = utf8d_pkg::LEN_TWO_BYTE;
      end else if (text_byte[7:4] == 4'b1110) begin
         lead_start = 1'b1;
         lead_pv    = {5'd0, text_byte[3:0], 12'd0};
         lead_rem   = utf8d_pkg::LEN_THREE_BYTE;
      end else if (text_byte[7:3] == 5'b11110) begin
         lead_start = 1'b1;
         lead_pv    = {text_byte[2:0], 18'd0};
         lead_rem   = utf8d_pkg::LEN_FOUR_BYTE;
      end else begin
         lead_emit = 1'b1;
         lead_bad  = 1'b1;
      end

      // Continuation payload placed by the count still expected after it.
      rem_dec = rem_ff - 2'd1;
      case (rem_dec)
         2'd0:    shifted = {15'd0, text_byte[5:0]};
         2'd1:    shifted = {9'd0, text_byte[5:0], 6'd0};
         2'd2:    shifted = {3'd0, text_byte[5:0], 12'd0};
         default: shifted = '0;
      endcase
      value = pv_ff | shifted;

      case (len_ff)
         utf8d_pkg::LEN_TWO_BYTE:
            overlong = (value != '0) && (value < utf8d_pkg::MIN_TWO_BYTE);
         utf8d_pkg::LEN_THREE_BYTE:
            overlong = (value < utf8d_pkg::MIN_THREE_BYTE);
         default:
            overlong = (value < utf8d_pkg::MIN_FOUR_BYTE);
      endcase

      pv_in  = pv_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      push_c = '0;

      if (rem_ff != 2'd0 && cont) begin
         rem_in = rem_dec;
         pv_in  = value;
         if (rem_dec == 2'd0) begin
            push_c.wr0                = 1'b1;
            push_c.entry0.code_point  = overlong ? '0 : value;
            push_c.entry0.malformed   = overlong;
            push_c.entry0.last_of_run = 1'b1;
            pv_in                     = '0;
         end
      end else begin
         if (rem_ff != 2'd0) begin
            // Broken sequence: report it, then treat the byte as a lead byte.
            push_c.wr0                = 1'b1;
            push_c.entry0.malformed   = 1'b1;
            push_c.entry0.last_of_run = !lead_emit;
            rem_in                    = 2'd0;
            pv_in                     = '0;
            if (lead_emit) begin
               push_c.wr1                = 1'b1;
               push_c.entry1.code_point  = lead_cp;
               push_c.entry1.malformed   = lead_bad;
               push_c.entry1.last_of_run = 1'b1;
            end
         end else if (lead_emit) begin
            push_c.wr0                = 1'b1;
            push_c.entry0.code_point  = lead_cp;
            push_c.entry0.malformed   = lead_bad;
            push_c.entry0.last_of_run = 1'b1;
         end
         if (lead_start) begin
            pv_in  = lead_pv;
            rem_in = lead_rem;
            len_in = lead_rem;
         end
      end

      push     = push_c;
      push.wr0 = push_c.wr0 && accept;
      push.wr1 = push_c.wr1 && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= '0;
         rem_ff <= 2'd0;
         len_ff <= 2'd0;
      end else if (accept) begin
         pv_ff  <= pv_in;
         rem_ff <= rem_in;
         len_ff <= len_in;
      end
   end

endmodule

// ----- rtl/utf8d_queue.sv -----
// Short result queue between the front and back parts; takes up to two items a cycle.
`timescale 1ns / 1ps

module utf8d_queue #(
   parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  utf8d_pkg::push_type             push,
   input  logic                            pop,
   output utf8d_pkg::result_type           head,
   output utf8d_pkg::queue_status_type     status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   utf8d_pkg::result_type mem_ff [DEPTH];
   logic [AW-1:0]         wptr_ff, wptr_in;
   logic [AW-1:0]         rptr_ff, rptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         wptr_next;

   always_comb begin
      wptr_next = wptr_ff + AW'(1);
      wptr_in   = wptr_ff + AW'(push.wr0) + AW'(push.wr1);
      rptr_in   = rptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);

      head                = mem_ff[rptr_ff];
      status.not_empty    = (count_ff != '0);
      status.room_for_two = (count_ff <= CW'(DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.wr0) begin
         mem_ff[wptr_ff] <= push.entry0;
      end
      if (push.wr1) begin
         mem_ff[wptr_next] <= push.entry1;
      end
   end

endmodule

// ----- rtl/utf8d_back.sv -----
// Back part: output register that hands queued results to the receiver.
`timescale 1ns / 1ps

module utf8d_back (
   input  logic                                clock,
   input  logic                                reset,
   input  utf8d_pkg::result_type               head,
   input  logic                                not_empty,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [utf8d_pkg::CP_WIDTH-1:0]      rsp_code_point,
   output logic                                rsp_malformed,
   output logic                                rsp_last_of_run
);

   logic                  valid_ff, valid_in;
   utf8d_pkg::result_type data_ff;
   logic                  load;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      pop      = load && not_empty;
      valid_in = load ? not_empty : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = data_ff.code_point;
   assign rsp_malformed   = data_ff.malformed;
   assign rsp_last_of_run = data_ff.last_of_run;

endmodule

// ----- rtl/utf8_code_point_decoder_unit.sv -----
// Top level of the UTF-8 code point decoder: front part, result queue and output stage.
`timescale 1ns / 1ps

// The block takes UTF-8 text one byte per item on the req_ channel and returns
// decoded code points on the rsp_ channel. Each result carries the code point,
// a malformed flag (the code point is then zero) and last_of_run, which marks
// the final result caused by one input byte. A byte gives zero, one or two
// results: a byte that breaks an unfinished sequence gives an error and is
// then decoded again as a lead byte. A zero byte gives no result of its own.
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low.
// An accepted byte has its results written into the queue and then moved to
// the output register. The front part takes one byte every cycle while
// req_stall is low; the output register, which sets the rate, hands out one
// result per cycle while rsp_stall is low, so a run of bytes with one result
// each streams at one byte per cycle. The queue holds QUEUE_DEPTH results,
// and req_stall rises when it has room for fewer than two, which is what a
// stalled receiver or a burst of two-result bytes causes.
// Reset (synchronous, active high) empties the queue and returns the decoder
// to idle with no sequence open.

module utf8_code_point_decoder_unit #(
   parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [utf8d_pkg::BYTE_WIDTH-1:0]    req_text_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [utf8d_pkg::CP_WIDTH-1:0]      rsp_code_point,
   output logic                                rsp_malformed,
   output logic                                rsp_last_of_run
);

   utf8d_pkg::push_type          push;
   utf8d_pkg::result_type        head;
   utf8d_pkg::queue_status_type  status;
   logic                         pop;
   logic                         accept;

   // The front part only needs room for the worst case of two results.
   assign req_stall = !status.room_for_two;
   assign accept    = req_valid && !req_stall;

   utf8d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .push      (push)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   utf8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .not_empty       (status.not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_malformed   (rsp_malformed),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
